// ===== rtl/seu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seu_pkg
// shared types and constants of the byte escaper / unescaper
// ----------------------------------------------------------------------------
package seu_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNESCAPE_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_SET_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_SET_HIGH = 2'd3;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]   escape_byte;
    logic         unescape_mode;
    logic [127:0] special_set;
  } cfg_t;

  // one output command: optional escape prefix, then the data word
  typedef struct packed {
    logic       pre;
    logic [7:0] esc;
    logic [7:0] data;
    logic       last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/seu_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seu_stream_if
// valid/ready byte channel with an end-of-string flag
// ----------------------------------------------------------------------------
interface seu_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/seu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seu_front
// accepts input words, classifies them and issues output commands
// ----------------------------------------------------------------------------
module seu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire seu_pkg::cfg_t cfg,
  input  wire logic         in_valid,
  input  wire logic [7:0]   in_data,
  input  wire logic         in_last,
  output logic              in_ready,
  input  wire logic         q_full,
  output logic              push,
  output seu_pkg::cmd_t     push_cmd
);
  import seu_pkg::*;

  logic pend_r, pend_nxt;
  logic accept;
  logic special;
  logic emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // bytes with the top bit set are never special
  assign special  = !in_data[7] && cfg.special_set[in_data[6:0]];

  always_comb begin
    emit         = 1'b1;
    pend_nxt     = 1'b0;
    push_cmd.pre  = 1'b0;
    push_cmd.esc  = cfg.escape_byte;
    push_cmd.data = in_data;
    push_cmd.last = in_last;
    if (cfg.escape_byte == 8'd0) begin
      // pass-through
    end else if (!cfg.unescape_mode) begin
      push_cmd.pre = special;
    end else if (!pend_r && (in_data == cfg.escape_byte)) begin
      // hold the escape word unless the string ends here
      if (!in_last) begin
        emit     = 1'b0;
        pend_nxt = 1'b1;
      end
    end else begin
      push_cmd.pre = pend_r && !special;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/seu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seu_queue
// short command fifo that decouples the front from the back
// ----------------------------------------------------------------------------
module seu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire seu_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output seu_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import seu_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/seu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seu_back
// expands commands into output words through an output register
// ----------------------------------------------------------------------------
module seu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire seu_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  output logic [7:0]         out_data,
  output logic               out_last,
  input  wire logic          out_ready
);
  import seu_pkg::*;

  logic       valid_r;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       phase_r, phase_nxt;
  logic       load;
  logic       send_pre;

  // output slot is free or drains this cycle
  assign load     = !empty && (!valid_r || out_ready);
  assign send_pre = head.pre && !phase_r;
  assign pop      = load && !send_pre;

  always_comb begin
    phase_nxt = phase_r;
    data_nxt  = head.data;
    last_nxt  = head.last;
    if (load) begin
      if (send_pre) begin
        data_nxt  = head.esc;
        last_nxt  = 1'b0;
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

// ===== rtl/stream_escape_unescape.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stream_escape_unescape
// byte-stream escaper and unescaper with a configurable special set
// ----------------------------------------------------------------------------
// usage
//   in_if  : sink of input words (a byte plus an end-of-string flag)
//   out_if : source of result words, same layout
//   cfg_*  : plain write port; index 0 escape byte, 1 unescape mode,
//            2 special set bits 0..63, 3 special set bits 64..127
//            write only while the block is idle
// throughput
//   one input word per cycle unless the queue is full; an escape plus data
//   word takes two output words, so the output register sets the rate
// data path
//   a result word is written into the queue at the edge that accepts its
//   input word and is loaded into the output register once the output
//   slot is free; a data word behind an escape prefix follows the prefix
//   into the output register when out_if.ready is high
// reset
//   rst_n low at a clock edge clears the queue, the output valid flag, the
//   held-escape flag and all configuration registers (pass-through mode)
// stalls
//   with out_if.ready low the output word holds; the two-entry queue still
//   takes new words until it is full, then in_if.ready drops
// ----------------------------------------------------------------------------
module stream_escape_unescape (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  seu_stream_if.sink                         in_if,
  seu_stream_if.source                       out_if,
  input  wire logic                          cfg_we,
  input  wire logic [seu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [seu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import seu_pkg::*;

  // configuration registers
  logic [7:0]  escape_byte_r;
  logic        unescape_mode_r;
  logic [63:0] special_low_r;
  logic [63:0] special_high_r;
  cfg_t        cfg;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  cmd_t head;
  logic q_empty;
  logic pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_byte_r   <= '0;
      unescape_mode_r <= 1'b0;
      special_low_r   <= '0;
      special_high_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESCAPE_BYTE:      escape_byte_r   <= cfg_wdata[7:0];
        CFG_UNESCAPE_MODE:    unescape_mode_r <= cfg_wdata[0];
        CFG_SPECIAL_SET_LOW:  special_low_r   <= cfg_wdata;
        CFG_SPECIAL_SET_HIGH: special_high_r  <= cfg_wdata;
      endcase
    end
  end

  assign cfg.escape_byte   = escape_byte_r;
  assign cfg.unescape_mode = unescape_mode_r;
  assign cfg.special_set   = {special_high_r, special_low_r};

  // classify the word and decide what to emit
  seu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_if.valid),
    .in_data  (in_if.data_byte),
    .in_last  (in_if.last),
    .in_ready (in_if.ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decoupling queue
  seu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // expand commands into one or two output words
  seu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_if.valid),
    .out_data  (out_if.data_byte),
    .out_last  (out_if.last),
    .out_ready (out_if.ready)
  );

endmodule
`default_nettype wire

// ===== rtl/seu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seu_checker
// port-level checks of the escaper, bound to the top level
// ----------------------------------------------------------------------------
module seu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data,
  input wire logic       out_last
);

  // no stale output word survives reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // queue is empty after reset, so input is open
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // input backpressure only comes from a held output word
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
    else $error("output word changed while stalled");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind stream_escape_unescape seu_checker u_seu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data_byte),
  .out_last  (out_if.last)
);
`default_nettype wire
